/* rtl/cap_pkg.sv */
// Shared types, constants and helper functions of the complex arithmetic and polar unit.
package cap_pkg;

  localparam int FRAC_BITS        = 16;
  localparam int ANGLE_ITERATIONS = 16;
  localparam int ANG_FRAC         = 16;
  localparam int ANG_W            = 25;
  localparam int QUO_W            = 32;
  localparam int DIV_W            = 64 + QUO_W;
  localparam int SQ_W             = 32;
  localparam int CX_W             = 35;
  localparam int Z_W              = 26;

  localparam logic [ANG_W-1:0] DEG90  = ANG_W'(90 << ANG_FRAC);
  localparam logic [ANG_W-1:0] DEG180 = ANG_W'(180 << ANG_FRAC);
  localparam logic [ANG_W-1:0] DEG360 = ANG_W'(360 << ANG_FRAC);

  localparam logic signed [65:0] S32_MAX = 66'sd2147483647;
  localparam logic signed [65:0] S32_MIN = -66'sd2147483648;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef struct packed {
    logic signed [31:0] v;
    logic               ovf;
  } sat_t;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] a_re;
    logic signed [31:0] a_im;
    logic signed [31:0] b_re;
    logic signed [31:0] b_im;
  } cap_in_t;

  typedef struct packed {
    op_t                op;
    logic               neg_re;
    logic               neg_im;
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic               ovf;
    logic [DIV_W-1:0]   num_re;
    logic [DIV_W-1:0]   num_im;
    logic [63:0]        den;
  } cap_dv_t;

  typedef struct packed {
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic               ovf;
    logic               dz;
  } cap_rect_t;

  typedef struct packed {
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic [31:0]        mag;
    logic [ANG_W-1:0]   ang;
    logic               dz;
    logic               ovf;
  } cap_res_t;

  // clamp a wide signed value into 32 bits
  function automatic sat_t sat66(input logic signed [65:0] x);
    sat_t r;
    r.v   = x[31:0];
    r.ovf = 1'b0;
    if (x > S32_MAX) begin
      r.v   = S32_MAX[31:0];
      r.ovf = 1'b1;
    end else if (x < S32_MIN) begin
      r.v   = S32_MIN[31:0];
      r.ovf = 1'b1;
    end
    return r;
  endfunction

  // atan(2^-i) in degrees, 16 fraction bits
  function automatic logic [21:0] atan_deg(input logic [4:0] idx);
    logic [21:0] r;
    case (idx)
      5'd0:    r = 22'd2949120;
      5'd1:    r = 22'd1740967;
      5'd2:    r = 22'd919879;
      5'd3:    r = 22'd466945;
      5'd4:    r = 22'd234379;
      5'd5:    r = 22'd117304;
      5'd6:    r = 22'd58666;
      5'd7:    r = 22'd29335;
      5'd8:    r = 22'd14668;
      5'd9:    r = 22'd7334;
      5'd10:   r = 22'd3667;
      5'd11:   r = 22'd1833;
      5'd12:   r = 22'd917;
      5'd13:   r = 22'd458;
      5'd14:   r = 22'd229;
      5'd15:   r = 22'd115;
      5'd16:   r = 22'd57;
      5'd17:   r = 22'd29;
      5'd18:   r = 22'd14;
      5'd19:   r = 22'd7;
      5'd20:   r = 22'd4;
      5'd21:   r = 22'd2;
      5'd22:   r = 22'd1;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/cap_in_if.sv */
// Operand channel: valid, ready and one operand beat.
interface cap_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic signed [31:0] a_re;
  logic signed [31:0] a_im;
  logic signed [31:0] b_re;
  logic signed [31:0] b_im;

  modport source(output valid, func, a_re, a_im, b_re, b_im, input ready);
  modport sink(input valid, func, a_re, a_im, b_re, b_im, output ready);
endinterface

/* rtl/cap_out_if.sv */
// Result channel: valid, ready and one result beat.
interface cap_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] res_re;
  logic signed [31:0] res_im;
  logic [31:0]        magnitude;
  logic [24:0]        angle_deg;
  logic               div_by_zero;
  logic               overflow;

  modport source(output valid, res_re, res_im, magnitude, angle_deg, div_by_zero, overflow,
                 input ready);
  modport sink(input valid, res_re, res_im, magnitude, angle_deg, div_by_zero, overflow,
               output ready);
endinterface

/* rtl/cap_front.sv */
// Front end: products and sums, then rectangular result or divider operands.
module cap_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  cap_pkg::cap_in_t  in_data,
  output logic              out_valid,
  output cap_pkg::cap_dv_t  out_data
);

  logic                    v1_r, v2_r;
  cap_pkg::op_t            op1_r;
  logic signed [63:0]      pp_rr_r, pp_ii_r, pp_ri_r, pp_ir_r, sq_r_r, sq_i_r;
  logic signed [32:0]      sum_re_r, sum_im_r;
  cap_pkg::cap_dv_t        dv_nxt, dv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1_r   <= in_data.op;
      pp_rr_r <= 64'(in_data.a_re) * 64'(in_data.b_re);
      pp_ii_r <= 64'(in_data.a_im) * 64'(in_data.b_im);
      pp_ri_r <= 64'(in_data.a_re) * 64'(in_data.b_im);
      pp_ir_r <= 64'(in_data.a_im) * 64'(in_data.b_re);
      sq_r_r  <= 64'(in_data.b_re) * 64'(in_data.b_re);
      sq_i_r  <= 64'(in_data.b_im) * 64'(in_data.b_im);
      if (in_data.op == cap_pkg::OP_SUB) begin
        sum_re_r <= 33'(in_data.a_re) - 33'(in_data.b_re);
        sum_im_r <= 33'(in_data.a_im) - 33'(in_data.b_im);
      end else begin
        sum_re_r <= 33'(in_data.a_re) + 33'(in_data.b_re);
        sum_im_r <= 33'(in_data.a_im) + 33'(in_data.b_im);
      end
      dv_r <= dv_nxt;
    end
  end

  always_comb begin
    logic signed [65:0] n_re, n_im, abs_re, abs_im;
    cap_pkg::sat_t      sr, si;
    n_re   = 66'(pp_rr_r) + 66'(pp_ii_r);
    n_im   = 66'(pp_ir_r) - 66'(pp_ri_r);
    abs_re = n_re[65] ? -n_re : n_re;
    abs_im = n_im[65] ? -n_im : n_im;
    case (op1_r)
      cap_pkg::OP_ADD, cap_pkg::OP_SUB: begin
        sr = cap_pkg::sat66(66'(sum_re_r));
        si = cap_pkg::sat66(66'(sum_im_r));
      end
      cap_pkg::OP_MUL: begin
        // floor of the scaled product
        sr = cap_pkg::sat66((66'(pp_rr_r) - 66'(pp_ii_r)) >>> cap_pkg::FRAC_BITS);
        si = cap_pkg::sat66((66'(pp_ri_r) + 66'(pp_ir_r)) >>> cap_pkg::FRAC_BITS);
      end
      default: begin
        sr = '0;
        si = '0;
      end
    endcase
    dv_nxt.op     = op1_r;
    dv_nxt.neg_re = n_re[65];
    dv_nxt.neg_im = n_im[65];
    dv_nxt.re     = sr.v;
    dv_nxt.im     = si.v;
    dv_nxt.ovf    = sr.ovf | si.ovf;
    dv_nxt.num_re = {{(cap_pkg::DIV_W-64){1'b0}}, abs_re[63:0]} << cap_pkg::FRAC_BITS;
    dv_nxt.num_im = {{(cap_pkg::DIV_W-64){1'b0}}, abs_im[63:0]} << cap_pkg::FRAC_BITS;
    dv_nxt.den    = $unsigned(sq_r_r) + $unsigned(sq_i_r);
  end

  assign out_valid = v2_r;
  assign out_data  = dv_r;

endmodule

/* rtl/cap_div.sv */
// Restoring divider pipeline, one quotient bit per stage, plus divide saturation.
module cap_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  cap_pkg::cap_dv_t   in_data,
  output logic               out_valid,
  output cap_pkg::cap_rect_t out_data
);

  localparam int QW = cap_pkg::QUO_W;
  localparam int DW = cap_pkg::DIV_W;

  typedef struct packed {
    cap_pkg::op_t       op;
    logic               neg_re;
    logic               neg_im;
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic               ovf;
    logic               dz;
    logic               qov_re;
    logic               qov_im;
    logic [DW-1:0]      rem_re;
    logic [DW-1:0]      rem_im;
    logic [63:0]        den;
    logic [QW-1:0]      q_re;
    logic [QW-1:0]      q_im;
  } dst_t;

  dst_t               d0_nxt;
  dst_t               st_r   [0:QW];
  dst_t               st_nxt [0:QW-1];
  logic [QW:0]        v_r;
  logic               vo_r;
  cap_pkg::cap_rect_t rect_nxt, rect_r;

  always_comb begin
    logic [DW-1:0] lim;
    lim           = {in_data.den, {QW{1'b0}}};
    d0_nxt.op     = in_data.op;
    d0_nxt.neg_re = in_data.neg_re;
    d0_nxt.neg_im = in_data.neg_im;
    d0_nxt.re     = in_data.re;
    d0_nxt.im     = in_data.im;
    d0_nxt.ovf    = in_data.ovf;
    d0_nxt.dz     = (in_data.den == '0);
    // quotient beyond 32 bits saturates anyway
    d0_nxt.qov_re = (in_data.num_re >= lim);
    d0_nxt.qov_im = (in_data.num_im >= lim);
    d0_nxt.rem_re = in_data.num_re;
    d0_nxt.rem_im = in_data.num_im;
    d0_nxt.den    = in_data.den;
    d0_nxt.q_re   = '0;
    d0_nxt.q_im   = '0;
  end

  always_comb begin
    logic [DW-1:0] d;
    for (int k = 0; k < QW; k++) begin
      d         = {{QW{1'b0}}, st_r[k].den} << (QW - 1 - k);
      st_nxt[k] = st_r[k];
      if (st_r[k].rem_re >= d) begin
        st_nxt[k].rem_re           = st_r[k].rem_re - d;
        st_nxt[k].q_re[QW - 1 - k] = 1'b1;
      end
      if (st_r[k].rem_im >= d) begin
        st_nxt[k].rem_im           = st_r[k].rem_im - d;
        st_nxt[k].q_im[QW - 1 - k] = 1'b1;
      end
    end
  end

  always_comb begin
    logic signed [65:0] m_re, m_im;
    cap_pkg::sat_t      sr, si;
    m_re = st_r[QW].qov_re ? (66'(1) << 40) : 66'(st_r[QW].q_re);
    m_im = st_r[QW].qov_im ? (66'(1) << 40) : 66'(st_r[QW].q_im);
    sr   = cap_pkg::sat66(st_r[QW].neg_re ? -m_re : m_re);
    si   = cap_pkg::sat66(st_r[QW].neg_im ? -m_im : m_im);
    rect_nxt.re  = st_r[QW].re;
    rect_nxt.im  = st_r[QW].im;
    rect_nxt.ovf = st_r[QW].ovf;
    rect_nxt.dz  = 1'b0;
    if (st_r[QW].op == cap_pkg::OP_DIV) begin
      if (st_r[QW].dz) begin
        rect_nxt.re  = '0;
        rect_nxt.im  = '0;
        rect_nxt.ovf = 1'b0;
        rect_nxt.dz  = 1'b1;
      end else begin
        rect_nxt.re  = sr.v;
        rect_nxt.im  = si.v;
        rect_nxt.ovf = sr.ovf | si.ovf;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r  <= '0;
      vo_r <= 1'b0;
    end else if (en) begin
      v_r  <= {v_r[QW-1:0], in_valid};
      vo_r <= v_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= d0_nxt;
      for (int k = 0; k < QW; k++) begin
        st_r[k+1] <= st_nxt[k];
      end
      rect_r <= rect_nxt;
    end
  end

  assign out_valid = vo_r;
  assign out_data  = rect_r;

endmodule

/* rtl/cap_polar.sv */
// Polar conversion: bit-per-stage square root alongside a vectoring CORDIC.
module cap_polar (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  cap_pkg::cap_rect_t in_data,
  output logic               out_valid,
  output cap_pkg::cap_res_t  out_data
);

  localparam int SW = cap_pkg::SQ_W;
  localparam int XW = cap_pkg::CX_W;
  localparam int ZW = cap_pkg::Z_W;
  localparam int AW = cap_pkg::ANG_W;

  typedef struct packed {
    cap_pkg::cap_rect_t rect;
    logic [31:0]        ur;
    logic [31:0]        ui;
    logic [63:0]        sqr;
    logic [63:0]        sqi;
  } p0_t;

  typedef struct packed {
    cap_pkg::cap_rect_t rect;
    logic               x0;
    logic               y0;
    logic [63:0]        e;
    logic [SW-1:0]      r;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } pst_t;

  p0_t               p0_nxt, p0_r;
  pst_t              p1_nxt;
  pst_t              st_r   [0:SW];
  pst_t              st_nxt [0:SW-1];
  logic              v0_r;
  logic [SW:0]       v_r;
  logic              vo_r;
  cap_pkg::cap_res_t res_nxt, res_r;

  always_comb begin
    p0_nxt.rect = in_data;
    p0_nxt.ur   = in_data.re[31] ? (~in_data.re + 32'd1) : in_data.re;
    p0_nxt.ui   = in_data.im[31] ? (~in_data.im + 32'd1) : in_data.im;
    p0_nxt.sqr  = 64'(p0_nxt.ur) * 64'(p0_nxt.ur);
    p0_nxt.sqi  = 64'(p0_nxt.ui) * 64'(p0_nxt.ui);
  end

  always_comb begin
    p1_nxt.rect = p0_r.rect;
    p1_nxt.x0   = (p0_r.ur == '0);
    p1_nxt.y0   = (p0_r.ui == '0);
    p1_nxt.e    = p0_r.sqr + p0_r.sqi;
    p1_nxt.r    = '0;
    p1_nxt.x    = XW'(p0_r.ur);
    p1_nxt.y    = XW'(p0_r.ui);
    p1_nxt.z    = '0;
  end

  // stage k settles root bit SW-1-k and, while iterations remain, one rotation
  always_comb begin
    logic [65:0]          t;
    logic signed [ZW-1:0] at;
    logic signed [XW-1:0] dx, dy;
    for (int k = 0; k < SW; k++) begin
      st_nxt[k] = st_r[k];
      t  = ({34'b0, st_r[k].r} << (SW - k)) + (66'(1) << (2 * (SW - 1 - k)));
      if ({2'b0, st_r[k].e} >= t) begin
        st_nxt[k].e                = st_r[k].e - t[63:0];
        st_nxt[k].r[SW - 1 - k]    = 1'b1;
      end
      at = ZW'(cap_pkg::atan_deg(5'(k)));
      dx = st_r[k].y >>> k;
      dy = st_r[k].x >>> k;
      if (k < cap_pkg::ANGLE_ITERATIONS) begin
        if (!st_r[k].y[XW-1] && (st_r[k].y != '0)) begin
          st_nxt[k].x = st_r[k].x + dx;
          st_nxt[k].y = st_r[k].y - dy;
          st_nxt[k].z = st_r[k].z + at;
        end else begin
          st_nxt[k].x = st_r[k].x - dx;
          st_nxt[k].y = st_r[k].y + dy;
          st_nxt[k].z = st_r[k].z - at;
        end
      end
    end
  end

  always_comb begin
    logic [AW-1:0] t, ang;
    logic          re_neg, im_neg;
    re_neg = st_r[SW].rect.re[31];
    im_neg = st_r[SW].rect.im[31];
    if (st_r[SW].y0) begin
      t = '0;
    end else if (st_r[SW].x0) begin
      t = cap_pkg::DEG90;
    end else if (st_r[SW].z[ZW-1]) begin
      t = '0;
    end else if (st_r[SW].z > $signed(ZW'(cap_pkg::DEG90))) begin
      t = cap_pkg::DEG90;
    end else begin
      t = st_r[SW].z[AW-1:0];
    end
    if (!re_neg && !im_neg) begin
      ang = t;
    end else if (re_neg && !im_neg) begin
      ang = cap_pkg::DEG180 - t;
    end else if (re_neg) begin
      ang = cap_pkg::DEG180 + t;
    end else begin
      ang = cap_pkg::DEG360 - t;
    end
    if (ang >= cap_pkg::DEG360) begin
      ang = '0;
    end
    res_nxt.re  = st_r[SW].rect.re;
    res_nxt.im  = st_r[SW].rect.im;
    res_nxt.mag = st_r[SW].r;
    res_nxt.ang = ang;
    res_nxt.dz  = st_r[SW].rect.dz;
    res_nxt.ovf = st_r[SW].rect.ovf;
    if (st_r[SW].x0 && st_r[SW].y0) begin
      res_nxt.mag = '0;
      res_nxt.ang = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v_r  <= '0;
      vo_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
      v_r  <= {v_r[SW-1:0], v0_r};
      vo_r <= v_r[SW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0_r    <= p0_nxt;
      st_r[0] <= p1_nxt;
      for (int k = 0; k < SW; k++) begin
        st_r[k+1] <= st_nxt[k];
      end
      res_r <= res_nxt;
    end
  end

  assign out_valid = vo_r;
  assign out_data  = res_r;

endmodule

/* rtl/complex_arith_polar_unit.sv */
// Complex add/subtract/multiply/divide with saturation and polar form of the result.
// Each accepted operand beat yields its result beat on out_if.
// Throughput: one beat per cycle; the 32-stage divider and 32-stage root pipelines set depth.
// The whole pipeline stalls together only when the output register holds a beat nobody takes
// and the last stage is full; an empty last stage lets the front keep accepting.
// Reset (synchronous, rst_n low) clears every valid bit; data registers are not reset.
module complex_arith_polar_unit (
  input  logic       clk,
  input  logic       rst_n,
  cap_in_if.sink     in_if,
  cap_out_if.source  out_if
);

  cap_pkg::cap_in_t   in_data;
  logic               adv;
  logic               fr_valid, dv_valid, pol_valid;
  cap_pkg::cap_dv_t   fr_data;
  cap_pkg::cap_rect_t dv_data;
  cap_pkg::cap_res_t  pol_data;
  logic               out_valid_r;
  cap_pkg::cap_res_t  out_r;

  // Advance every stage unless the output register is blocked and the tail is occupied.
  assign adv         = !out_valid_r || out_if.ready || !pol_valid;
  assign in_if.ready = adv;

  assign in_data.op   = cap_pkg::op_t'(in_if.func);
  assign in_data.a_re = in_if.a_re;
  assign in_data.a_im = in_if.a_im;
  assign in_data.b_re = in_if.b_re;
  assign in_data.b_im = in_if.b_im;

  // Products and sums, then rectangular result or divider operands.
  cap_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (in_if.valid),
    .in_data   (in_data),
    .out_valid (fr_valid),
    .out_data  (fr_data)
  );

  // Quotient bits for divide; other operations ride through unchanged.
  cap_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (fr_valid),
    .in_data   (fr_data),
    .out_valid (dv_valid),
    .out_data  (dv_data)
  );

  // Magnitude and angle of the saturated rectangular result.
  cap_polar u_polar (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (dv_valid),
    .in_data   (dv_data),
    .out_valid (pol_valid),
    .out_data  (pol_data)
  );

  // Output register: load when empty or when the waiting beat is taken, otherwise hold.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_if.ready) begin
      out_valid_r <= pol_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_if.ready) begin
      out_r <= pol_data;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.res_re      = out_r.re;
  assign out_if.res_im      = out_r.im;
  assign out_if.magnitude   = out_r.mag;
  assign out_if.angle_deg   = out_r.ang;
  assign out_if.div_by_zero = out_r.dz;
  assign out_if.overflow    = out_r.ovf;

endmodule
